// ===== sv/rtwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record table package
// Types, constants and command/status bundles for the record table.
// ----------------------------------------------------------------------------
package rtwc_pkg;

	localparam int CAPACITY   = 1024;
	localparam int NUM_COORDS = 16;
	localparam int COORD_BITS = 32;
	localparam int FACE_WORDS = 4;

	// longest per-record copy sequence
	localparam int MAX_WORDS = (NUM_COORDS > FACE_WORDS) ? NUM_COORDS : FACE_WORDS;

	localparam int SLOT_W  = 10;
	localparam int PART_W  = 4;
	localparam int VALUE_W = 64;
	localparam int COUNT_W = 11;
	localparam int MARK_W  = 2;

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int TOP_W   = $clog2(CAPACITY + 1);
	localparam int CADDR_W = $clog2(CAPACITY * NUM_COORDS);
	localparam int FADDR_W = $clog2(CAPACITY * FACE_WORDS);
	localparam int STEP_W  = $clog2(MAX_WORDS + 1);

	localparam logic [MARK_W-1:0] U_USED = 2'd1;
	localparam logic [MARK_W-1:0] U_POS  = 2'd2;
	localparam logic [MARK_W-1:0] U_NEG  = 2'd3;

	typedef enum logic [2:0] {
		OP_ALLOC    = 3'd0,
		OP_WR_COORD = 3'd1,
		OP_WR_FACE  = 3'd2,
		OP_SET_MARK = 3'd3,
		OP_RD_COORD = 3'd4,
		OP_RD_FACE  = 3'd5,
		OP_RD_MARK  = 3'd6,
		OP_COMPACT  = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [SLOT_W-1:0]   slot;
		logic [PART_W-1:0]   part;
		logic [VALUE_W-1:0]  write_value;
		logic [MARK_W-1:0]   mark_value;
	} in_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  read_value;
		logic [SLOT_W-1:0]   new_slot;
		logic [COUNT_W-1:0]  record_count;
		status_t             status;
	} out_t;

	typedef struct packed {
		logic do_op;      // run a single-record operation on the input beat
		logic start_cmp;  // begin compaction
		logic cmp_check;  // test end of compaction, fetch both marks
		logic decide;     // drop top, skip current or start a move
		logic copy_step;  // one copy step of a record move
		logic load_out;   // load the result register
	} dp_cmd_t;

	typedef struct packed {
		logic top_zero;
		logic cur_ge_top;
		logic mark_top_neg;
		logic mark_cur_neg;
		logic copy_last;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== sv/rtwc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record table controller
// Handshake and sequencing of single operations and of the compaction walk.
// ----------------------------------------------------------------------------
module rtwc_ctrl import rtwc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire opcode_t in_opcode,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CCHK = 5'b00010,
		S_CDEC = 5'b00100,
		S_COPY = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	logic   move;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign move      = sts.mark_cur_neg && !sts.mark_top_neg;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_opcode == OP_COMPACT) begin
						cmd.start_cmp = 1'b1;
						state_d       = S_CCHK;
					end else begin
						cmd.do_op = 1'b1;
						state_d   = S_DONE;
					end
				end
			end
			S_CCHK: begin
				cmd.cmp_check = 1'b1;
				if (sts.top_zero || sts.cur_ge_top)
					state_d = S_DONE;
				else
					state_d = S_CDEC;
			end
			S_CDEC: begin
				cmd.decide = 1'b1;
				state_d    = move ? S_COPY : S_CCHK;
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_last)
					state_d = S_CCHK;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending beat");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second beat taken while an operation runs");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the done state");

endmodule
`default_nettype wire

// ===== sv/rtwc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record table datapath
// Coordinate, face and mark memories, top and cursor counters, result register.
// ----------------------------------------------------------------------------
module rtwc_dp import rtwc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire in_t     in_data,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts,
	output out_t         out_data
);

	logic [COORD_BITS-1:0] coord_mem [CAPACITY*NUM_COORDS];
	logic [VALUE_W-1:0]    face_mem  [CAPACITY*FACE_WORDS];
	logic [MARK_W-1:0]     mark_mem  [CAPACITY];

	logic [TOP_W-1:0]      top_q;
	logic [TOP_W-1:0]      cur_q;
	logic [STEP_W-1:0]     step_q;
	opcode_t               op_q;
	status_t               st_q;
	logic [SLOT_W-1:0]     ns_q;
	logic [MARK_W-1:0]     mark_a_q;
	logic [MARK_W-1:0]     mark_b_q;
	logic [COORD_BITS-1:0] coord_rd_q;
	logic [VALUE_W-1:0]    face_rd_q;
	out_t                  out_q;

	logic                  slot_ok, coord_ok, face_ok, full;
	logic [TOP_W-1:0]      top_m1;
	logic [IDX_W-1:0]      src_idx, dst_idx, slot_idx;
	logic [STEP_W-1:0]     step_m1;
	logic [CADDR_W-1:0]    c_in_addr;
	logic [FADDR_W-1:0]    f_in_addr;

	logic                  c_we, c_re, f_we, f_re, m_we, m_re;
	logic [CADDR_W-1:0]    c_waddr, c_raddr;
	logic [FADDR_W-1:0]    f_waddr, f_raddr;
	logic [COORD_BITS-1:0] c_wdata;
	logic [VALUE_W-1:0]    f_wdata;
	logic [IDX_W-1:0]      m_waddr, m_raddr_a;
	logic [MARK_W-1:0]     m_wdata;
	status_t               st_op;
	logic [VALUE_W-1:0]    rd_val;

	assign slot_ok  = TOP_W'(in_data.slot) < top_q;
	assign coord_ok = slot_ok && (32'(in_data.part) < NUM_COORDS);
	assign face_ok  = slot_ok && (32'(in_data.part) < FACE_WORDS);
	assign full     = top_q >= TOP_W'(CAPACITY);
	assign top_m1   = top_q - 1'b1;
	assign src_idx  = top_m1[IDX_W-1:0];
	assign dst_idx  = cur_q[IDX_W-1:0];
	assign slot_idx = in_data.slot[IDX_W-1:0];
	assign step_m1  = step_q - 1'b1;

	assign c_in_addr = CADDR_W'(slot_idx) * CADDR_W'(NUM_COORDS) + CADDR_W'(in_data.part);
	assign f_in_addr = FADDR_W'(slot_idx) * FADDR_W'(FACE_WORDS) + FADDR_W'(in_data.part);

	// memory port steering
	always_comb begin
		c_we    = 1'b0;
		c_re    = 1'b0;
		f_we    = 1'b0;
		f_re    = 1'b0;
		m_we    = 1'b0;
		m_re    = cmd.do_op || cmd.cmp_check;
		c_waddr = CADDR_W'(dst_idx) * CADDR_W'(NUM_COORDS) + CADDR_W'(step_m1);
		c_raddr = CADDR_W'(src_idx) * CADDR_W'(NUM_COORDS) + CADDR_W'(step_q);
		c_wdata = coord_rd_q;
		f_waddr = FADDR_W'(dst_idx) * FADDR_W'(FACE_WORDS) + FADDR_W'(step_m1);
		f_raddr = FADDR_W'(src_idx) * FADDR_W'(FACE_WORDS) + FADDR_W'(step_q);
		f_wdata = face_rd_q;
		m_waddr = dst_idx;
		m_wdata = mark_b_q;
		m_raddr_a = cmd.do_op ? slot_idx : dst_idx;
		if (cmd.do_op) begin
			c_waddr = c_in_addr;
			c_raddr = c_in_addr;
			c_wdata = in_data.write_value[COORD_BITS-1:0];
			f_waddr = f_in_addr;
			f_raddr = f_in_addr;
			f_wdata = in_data.write_value;
			c_we    = (in_data.opcode == OP_WR_COORD) && coord_ok;
			c_re    = (in_data.opcode == OP_RD_COORD);
			f_we    = (in_data.opcode == OP_WR_FACE) && face_ok;
			f_re    = (in_data.opcode == OP_RD_FACE);
			if (in_data.opcode == OP_ALLOC && !full) begin
				m_we    = 1'b1;
				m_waddr = top_q[IDX_W-1:0];
				m_wdata = U_USED;
			end else if (in_data.opcode == OP_SET_MARK && slot_ok) begin
				m_we    = 1'b1;
				m_waddr = slot_idx;
				m_wdata = in_data.mark_value;
			end
		end else if (cmd.copy_step) begin
			// read word k of the source while word k-1 lands at the hole
			c_re = 32'(step_q) < NUM_COORDS;
			f_re = 32'(step_q) < FACE_WORDS;
			c_we = (step_q != '0) && (32'(step_m1) < NUM_COORDS);
			f_we = (step_q != '0) && (32'(step_m1) < FACE_WORDS);
			m_we = sts.copy_last;
		end
	end

	always_ff @(posedge clk) begin
		if (c_we)
			coord_mem[c_waddr] <= c_wdata;
		if (c_re)
			coord_rd_q <= coord_mem[c_raddr];
	end

	always_ff @(posedge clk) begin
		if (f_we)
			face_mem[f_waddr] <= f_wdata;
		if (f_re)
			face_rd_q <= face_mem[f_raddr];
	end

	always_ff @(posedge clk) begin
		if (m_we)
			mark_mem[m_waddr] <= m_wdata;
		if (m_re) begin
			mark_a_q <= mark_mem[m_raddr_a];
			mark_b_q <= mark_mem[src_idx];
		end
	end

	always_comb begin
		st_op = ST_OK;
		case (in_data.opcode)
			OP_ALLOC:                 if (full) st_op = ST_FULL;
			OP_WR_COORD, OP_RD_COORD: if (!coord_ok) st_op = ST_RANGE;
			OP_WR_FACE, OP_RD_FACE:   if (!face_ok) st_op = ST_RANGE;
			OP_SET_MARK, OP_RD_MARK:  if (!slot_ok) st_op = ST_RANGE;
			default:                  st_op = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			cur_q  <= '0;
			step_q <= '0;
			op_q   <= OP_ALLOC;
			st_q   <= ST_OK;
			ns_q   <= '0;
		end else begin
			if (cmd.do_op) begin
				op_q <= in_data.opcode;
				st_q <= st_op;
				ns_q <= '0;
				if (in_data.opcode == OP_ALLOC && !full) begin
					ns_q  <= top_q[SLOT_W-1:0];
					top_q <= top_q + 1'b1;
				end
			end
			if (cmd.start_cmp) begin
				op_q <= OP_COMPACT;
				ns_q <= '0;
				cur_q <= '0;
			end
			if (cmd.cmp_check)
				st_q <= (top_q == '0) ? ST_EMPTY : ST_OK;
			if (cmd.decide) begin
				if (mark_b_q == U_NEG)
					top_q <= top_m1;
				else if (mark_a_q != U_NEG)
					cur_q <= cur_q + 1'b1;
				else
					step_q <= '0;
			end
			if (cmd.copy_step) begin
				if (sts.copy_last) begin
					cur_q <= cur_q + 1'b1;
					top_q <= top_m1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		rd_val = '0;
		if (st_q == ST_OK) begin
			case (op_q)
				OP_RD_COORD: rd_val = VALUE_W'(signed'(coord_rd_q));
				OP_RD_FACE:  rd_val = face_rd_q;
				OP_RD_MARK:  rd_val = VALUE_W'(mark_a_q);
				default:     rd_val = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.read_value   <= rd_val;
			out_q.new_slot     <= ns_q;
			out_q.record_count <= COUNT_W'(top_q);
			out_q.status       <= st_q;
		end
	end

	assign out_data = out_q;

	assign sts.top_zero     = (top_q == '0);
	assign sts.cur_ge_top   = (cur_q >= top_q);
	assign sts.mark_top_neg = (mark_b_q == U_NEG);
	assign sts.mark_cur_neg = (mark_a_q == U_NEG);
	assign sts.copy_last    = (32'(step_q) == MAX_WORDS);

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_W'(CAPACITY))
		else $error("top count beyond capacity");

	a_cur_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= top_q)
		else $error("compaction cursor passed the top");

	a_move_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_step |-> (dst_idx != src_idx) && (mark_b_q != U_NEG))
		else $error("record move onto itself or from a negative record");

endmodule
`default_nettype wire

// ===== sv/record_table_with_compaction.sv =====
// Single-record results are loaded from the done state once the output is free.
// A new operation is accepted only in the idle state, after the previous result is loaded.
// Compaction: check and decide states per examined record, plus copy steps per record moved
// from the top into a hole (one word pair copied per cycle through the memory ports).
// Reset clears the record count and the controller; memory contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record table with compaction
// Fixed-capacity record table with stack allocation and top-to-hole move compaction.
// ----------------------------------------------------------------------------
module record_table_with_compaction import rtwc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	rtwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_opcode (in_data.opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rtwc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
`default_nettype wire
